### sv/cft_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the count-sorted frequency table.
// Used by cft_cell, cft_ctrl and the top level; depends on nothing.
package cft_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KEY_W    = 64;
  localparam int COUNT_W  = 32;
  localparam int RANK_W   = 7;
  localparam int STATUS_W = 2;
  // index bits for the largest supported table (4096 entries)
  localparam int IDX_W    = 12;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_COUNTED  = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_RANK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_WALK,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_out;
    logic [COUNT_W-1:0] count_out;
    logic [RANK_W-1:0]  rank_out;
    status_t            status;
  } out_word_t;

  // request token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic               valid;
    logic               req_type;
    logic [KEY_W-1:0]   key;
    logic [RANK_W-1:0]  rank;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hit_start;
    logic [IDX_W-1:0]   run_start;
    logic [COUNT_W-1:0] prev_count;
    logic [KEY_W-1:0]   cap_key;
    logic [COUNT_W-1:0] cap_count;
  } token_t;

  // table write: cell lo takes the new entry, cells lo+1..hi take their upper neighbor
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } upd_t;

endpackage

### sv/count_sorted_frequency_table.sv
`timescale 1ns / 1ps
// Frequency table kept in descending count order, built as a chain of CAPACITY cells.
// Each accepted request word yields one result word; the token walks every cell once.
// A new request is accepted only after the previous result word has been registered.
// Reset clears the entry count, control state and tokens but not the cells, which are written before they are read.
// Depends on cft_pkg, cft_cell and cft_ctrl.
module count_sorted_frequency_table #(
  parameter int CAPACITY   = cft_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = cft_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cft_pkg::in_word_t  req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output cft_pkg::out_word_t rsp_data
);
  import cft_pkg::*;

  localparam int USED_W = $clog2(CAPACITY+1);

  token_t                tok [CAPACITY+1];
  upd_t                  upd;
  logic [USED_W-1:0]     used;
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [COUNT_BITS-1:0] cell_count [CAPACITY];

  cft_ctrl #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data),
    .tok_inject (tok[0]),
    .tok_exit   (tok[CAPACITY]),
    .upd        (upd),
    .used       (used)
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KEY_BITS-1:0]   nb_key;
    logic [COUNT_BITS-1:0] nb_count;

    if (j == 0) begin : g_head
      assign nb_key   = '0;
      assign nb_count = '0;
    end else begin : g_body
      assign nb_key   = cell_key[j-1];
      assign nb_count = cell_count[j-1];
    end

    cft_cell #(
      .INDEX      (j),
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .used       (used),
      .tok_in     (tok[j]),
      .tok_out    (tok[j+1]),
      .upd        (upd),
      .nb_key     (nb_key),
      .nb_count   (nb_count),
      .cell_key   (cell_key[j]),
      .cell_count (cell_count[j])
    );
  end

endmodule

### sv/cft_cell.sv
`timescale 1ns / 1ps
// One table cell: holds a key and its count, and advances the request token.
// Depends on cft_pkg.
module cft_cell #(
  parameter int INDEX      = 0,
  parameter int CAPACITY   = cft_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = cft_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(CAPACITY+1)-1:0]      used,
  input  cft_pkg::token_t                    tok_in,
  output cft_pkg::token_t                    tok_out,
  input  cft_pkg::upd_t                      upd,
  input  logic [KEY_BITS-1:0]                nb_key,
  input  logic [COUNT_BITS-1:0]              nb_count,
  output logic [KEY_BITS-1:0]                cell_key,
  output logic [COUNT_BITS-1:0]              cell_count
);
  import cft_pkg::*;

  localparam int USED_W = $clog2(CAPACITY+1);

  logic [KEY_BITS-1:0]   key_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [COUNT_W-1:0]    cnt_ext;
  logic [IDX_W-1:0]      my_idx;
  logic [IDX_W-1:0]      run_new;
  logic                  in_use;
  logic                  key_hit;
  logic                  rank_hit;
  token_t                tok_next;

  assign my_idx     = IDX_W'(INDEX);
  assign cnt_ext    = COUNT_W'(count_q);
  assign cell_key   = key_q;
  assign cell_count = count_q;

  always_comb begin
    in_use   = USED_W'(INDEX) < used;
    // a new run of equal counts starts where the count differs from the cell above
    run_new  = (INDEX == 0 || cnt_ext != tok_in.prev_count) ? my_idx : tok_in.run_start;
    key_hit  = tok_in.req_type == REQ_ADD && !tok_in.found && in_use &&
               key_q == tok_in.key[KEY_BITS-1:0];
    rank_hit = tok_in.req_type == REQ_QUERY && 32'(tok_in.rank) == 32'(INDEX + 1);

    tok_next            = tok_in;
    tok_next.run_start  = run_new;
    tok_next.prev_count = cnt_ext;
    if (key_hit) begin
      tok_next.found     = 1'b1;
      tok_next.hit_idx   = my_idx;
      tok_next.hit_start = run_new;
      tok_next.cap_count = cnt_ext;
    end
    if (rank_hit) begin
      tok_next.cap_key   = KEY_W'(key_q);
      tok_next.cap_count = cnt_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.we && my_idx == upd.lo) begin
      key_q   <= upd.key[KEY_BITS-1:0];
      count_q <= upd.count[COUNT_BITS-1:0];
    end else if (upd.we && my_idx > upd.lo && my_idx <= upd.hi) begin
      // shift down one place to open the slot for the promoted entry
      key_q   <= nb_key;
      count_q <= nb_count;
    end
  end

endmodule

### sv/cft_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: injects request tokens, finishes them at the chain tail,
// issues table writes, keeps the entry count and holds the result word.
// Depends on cft_pkg.
module cft_ctrl #(
  parameter int CAPACITY   = cft_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = cft_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  cft_pkg::in_word_t             req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output cft_pkg::out_word_t            rsp_data,
  output cft_pkg::token_t               tok_inject,
  input  cft_pkg::token_t               tok_exit,
  output cft_pkg::upd_t                 upd,
  output logic [$clog2(CAPACITY+1)-1:0] used
);
  import cft_pkg::*;

  localparam int USED_W = $clog2(CAPACITY+1);

  ctrl_state_t        state;
  ctrl_state_t        state_next;
  token_t             held;
  logic               accept;
  logic               done;
  logic               insert;
  logic               sat;
  logic [KEY_W-1:0]   key_m;
  logic [COUNT_W-1:0] new_count;
  logic [IDX_W-1:0]   pos;
  out_word_t          word;
  upd_t               cmd;

  assign accept = req_valid && req_ready;
  assign done   = state == CS_DONE && (!rsp_valid || rsp_ready);
  assign upd    = done ? cmd : '0;

  always_comb begin
    tok_inject          = '0;
    tok_inject.valid    = accept;
    tok_inject.req_type = req_data.req_type;
    tok_inject.key      = KEY_W'(req_data.key[KEY_BITS-1:0]);
    tok_inject.rank     = req_data.rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      CS_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = CS_WALK;
        end
      end
      CS_WALK: begin
        if (tok_exit.valid) begin
          state_next = CS_DONE;
        end
      end
      CS_DONE: begin
        if (done) begin
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  // hold the finished token until the result register is free
  always_ff @(posedge clk) begin
    if (state == CS_WALK && tok_exit.valid) begin
      held <= tok_exit;
    end
  end

  always_comb begin
    key_m     = KEY_W'(held.key[KEY_BITS-1:0]);
    sat       = held.cap_count[COUNT_BITS-1:0] == {COUNT_BITS{1'b1}};
    new_count = sat ? held.cap_count : held.cap_count + COUNT_W'(1);
    pos       = sat ? held.hit_idx : held.hit_start;
    insert    = 1'b0;
    cmd       = '0;
    word      = '0;
    if (held.req_type == REQ_QUERY) begin
      if (held.rank != '0 && 32'(held.rank) <= 32'(used)) begin
        word.key_out   = held.cap_key;
        word.count_out = held.cap_count;
        word.rank_out  = held.rank;
        word.status    = STAT_COUNTED;
      end else begin
        word.status    = STAT_BAD_RANK;
      end
    end else if (held.found) begin
      // promote to the head of its old equal-count run; a saturated count stays put
      cmd.we         = !sat;
      cmd.lo         = held.hit_start;
      cmd.hi         = held.hit_idx;
      cmd.key        = key_m;
      cmd.count      = new_count;
      word.key_out   = key_m;
      word.count_out = new_count;
      word.rank_out  = RANK_W'(pos + IDX_W'(1));
      word.status    = STAT_COUNTED;
    end else if (32'(used) == 32'(CAPACITY)) begin
      word.key_out   = key_m;
      word.status    = STAT_FULL;
    end else begin
      insert         = 1'b1;
      cmd.we         = 1'b1;
      cmd.lo         = IDX_W'(used);
      cmd.hi         = IDX_W'(used);
      cmd.key        = key_m;
      cmd.count      = COUNT_W'(1);
      word.key_out   = key_m;
      word.count_out = COUNT_W'(1);
      word.rank_out  = RANK_W'(used + USED_W'(1));
      word.status    = STAT_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (done && insert) begin
      used <= used + USED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_data <= word;
    end
  end

endmodule
